FILE: rtl/mafc_pkg.sv
// Shared types, constants and helpers for the motor arming and failsafe controller.
// Depends on nothing; every other file of the block uses it.
package mafc_pkg;

   // Longest command line that is kept; further characters are dropped.
   localparam int LINE_MAX   = 31;
   localparam int LINE_CNT_W = $clog2(LINE_MAX + 1);

   localparam int BYTE_W     = 8;
   localparam int MODE_W     = 2;
   localparam int PULSE_W    = 15;
   localparam int TICK_W     = 16;
   localparam int ACC_W      = 15;
   localparam int STATE_W    = 2;
   localparam int EVENT_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // The decimal value saturates here; one digit step needs four more bits.
   localparam logic [ACC_W-1:0] NUM_SAT = {ACC_W{1'b1}};
   localparam int ACC_STEP_W = ACC_W + 4;

   localparam logic [PULSE_W-1:0] MIN_PULSE_RST = PULSE_W'(1000);
   localparam logic [PULSE_W-1:0] MAX_PULSE_RST = PULSE_W'(2000);
   localparam logic [TICK_W-1:0]  TIMEOUT_RST   = TICK_W'(500);
   localparam logic [TICK_W-1:0]  REPORT_RST    = TICK_W'(100);
   localparam logic [TICK_W-1:0]  TICK_SAT      = {TICK_W{1'b1}};

   // Characters of the command language.
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_ARM     = 8'h41;
   localparam logic [BYTE_W-1:0] CH_DISARM  = 8'h44;
   localparam logic [BYTE_W-1:0] CH_REARM   = 8'h52;
   localparam logic [BYTE_W-1:0] CH_SET     = 8'h53;
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

   typedef enum logic [MODE_W-1:0] {
      MODE_BYTE = 2'd0,
      MODE_TICK = 2'd1,
      MODE_KILL = 2'd2
   } mode_type;

   typedef enum logic [STATE_W-1:0] {
      ST_DISARMED = 2'd0,
      ST_ARMED    = 2'd1,
      ST_KILLED   = 2'd2
   } arm_state_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE     = 3'd0,
      EV_ARMED    = 3'd1,
      EV_DISARMED = 3'd2,
      EV_KILLED   = 3'd3,
      EV_TIMEOUT  = 3'd4
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_PULSE     = 2'd0,
      CSR_MAX_PULSE     = 2'd1,
      CSR_TIMEOUT_TICKS = 2'd2,
      CSR_REPORT_PERIOD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PULSE_W-1:0] min_pulse;
      logic [PULSE_W-1:0] max_pulse;
      logic [TICK_W-1:0]  timeout_ticks;
      logic [TICK_W-1:0]  report_period;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] head;
      logic              has_chars;
      logic [ACC_W-1:0]  value;
   } line_info_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_width;
      logic               drive_enable;
      logic [STATE_W-1:0] arm_state;
      logic [EVENT_W-1:0] event_res;
      logic               report_due;
   } result_type;

   // Raise to the minimum first, then lower to the maximum, so the maximum
   // wins when the two limits are inverted.
   function automatic logic [PULSE_W-1:0] clamp_pulse(
      input logic [PULSE_W-1:0] v,
      input logic [PULSE_W-1:0] lo,
      input logic [PULSE_W-1:0] hi
   );
      logic [PULSE_W-1:0] r;
      r = (v < lo) ? lo : v;
      r = (r > hi) ? hi : r;
      return r;
   endfunction

endpackage

FILE: rtl/mafc_if.sv
// Valid/ready channel interfaces for the controller's command and result beats.
// Depends on mafc_pkg for the field widths.
interface mafc_req_if;
   logic                       valid;
   logic                       ready;
   logic [mafc_pkg::MODE_W-1:0] mode;
   logic [mafc_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface mafc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mafc_pkg::PULSE_W-1:0] pulse_width;
   logic                         drive_enable;
   logic [mafc_pkg::STATE_W-1:0] arm_state;
   logic [mafc_pkg::EVENT_W-1:0] event_res;
   logic                         report_due;

   modport source (output valid, output pulse_width, output drive_enable,
                   output arm_state, output event_res, output report_due,
                   input ready);
   modport sink   (input valid, input pulse_width, input drive_enable,
                   input arm_state, input event_res, input report_due,
                   output ready);
endinterface

FILE: rtl/mafc_line.sv
// Command line assembler: keeps the head character, the length and the decimal value.
// Depends on mafc_pkg.
module mafc_line (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [mafc_pkg::MODE_W-1:0]   mode,
   input  logic [mafc_pkg::BYTE_W-1:0]   rx_byte,
   output mafc_pkg::line_info_type       line_info
);
   import mafc_pkg::*;

   logic [BYTE_W-1:0]     head_ff, head_in;
   logic [LINE_CNT_W-1:0] count_ff, count_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic                  open_ff, open_in;
   logic                  is_digit;
   logic [ACC_STEP_W-1:0] acc_step;

   assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

   // acc * 10 + digit, as two shifted copies and an add.
   assign acc_step = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0}
                   + ACC_STEP_W'(rx_byte - CH_ZERO);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      open_in  = open_ff;
      if (step_en && (mode == MODE_BYTE)) begin
         if (rx_byte == CH_NEWLINE) begin
            head_in  = '0;
            count_in = '0;
            acc_in   = '0;
            open_in  = 1'b0;
         end else if (count_ff < LINE_CNT_W'(LINE_MAX)) begin
            if (count_ff == '0) begin
               head_in = rx_byte;
               acc_in  = '0;
               open_in = 1'b1;
            end else if (open_ff && is_digit) begin
               acc_in = (acc_step > ACC_STEP_W'(NUM_SAT)) ? NUM_SAT : acc_step[ACC_W-1:0];
            end else begin
               open_in = 1'b0;
            end
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         acc_ff   <= '0;
         open_ff  <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         open_ff  <= open_in;
      end
   end

   assign line_info.head      = head_ff;
   assign line_info.has_chars = (count_ff != '0);
   assign line_info.value     = acc_ff;

endmodule

FILE: rtl/mafc_ctrl.sv
// Arming state, throttle, silence timeout and report timer; forms each result.
// Depends on mafc_pkg.
module mafc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [mafc_pkg::MODE_W-1:0]   mode,
   input  logic [mafc_pkg::BYTE_W-1:0]   rx_byte,
   input  mafc_pkg::line_info_type       line_info,
   input  mafc_pkg::cfg_type             cfg,
   output mafc_pkg::result_type          result
);
   import mafc_pkg::*;

   logic [STATE_W-1:0] state_ff, state_in;
   logic               enable_ff, enable_in;
   logic [PULSE_W-1:0] throttle_ff, throttle_in;
   logic [TICK_W-1:0]  silence_ff, silence_in;
   logic [TICK_W-1:0]  report_ff, report_in;
   logic [TICK_W-1:0]  report_next;
   logic [PULSE_W-1:0] idle_pulse;
   logic [EVENT_W-1:0] event_code;
   logic               due;

   assign idle_pulse  = clamp_pulse(cfg.min_pulse, cfg.min_pulse, cfg.max_pulse);
   assign report_next = report_ff + 1'b1;

   always_comb begin
      state_in    = state_ff;
      enable_in   = enable_ff;
      throttle_in = throttle_ff;
      silence_in  = silence_ff;
      report_in   = report_ff;
      event_code  = EV_NONE;
      due         = 1'b0;
      case (mode)
         MODE_BYTE: begin
            if ((rx_byte == CH_NEWLINE) && line_info.has_chars) begin
               if ((line_info.head == CH_ARM) && (state_ff != ST_KILLED)) begin
                  state_in    = ST_ARMED;
                  silence_in  = '0;
                  throttle_in = idle_pulse;
                  event_code  = EV_ARMED;
               end else if (line_info.head == CH_DISARM) begin
                  state_in    = ST_DISARMED;
                  throttle_in = idle_pulse;
                  event_code  = EV_DISARMED;
               end else if ((line_info.head == CH_REARM) && (state_ff == ST_KILLED)) begin
                  enable_in  = 1'b1;
                  state_in   = ST_DISARMED;
                  event_code = EV_DISARMED;
               end else if ((line_info.head == CH_SET) && (state_ff == ST_ARMED)) begin
                  throttle_in = clamp_pulse(line_info.value, cfg.min_pulse, cfg.max_pulse);
                  silence_in  = '0;
               end
            end
         end
         MODE_TICK: begin
            if ((state_ff == ST_ARMED) && (silence_ff >= cfg.timeout_ticks)) begin
               state_in    = ST_DISARMED;
               throttle_in = idle_pulse;
               event_code  = EV_TIMEOUT;
            end
            if (silence_ff != TICK_SAT) begin
               silence_in = silence_ff + 1'b1;
            end
            // The count stays below the largest period, so the increment cannot wrap.
            if (report_next >= cfg.report_period) begin
               report_in = '0;
               due       = 1'b1;
            end else begin
               report_in = report_next;
            end
         end
         MODE_KILL: begin
            if (state_ff == ST_KILLED) begin
               enable_in  = 1'b1;
               state_in   = ST_DISARMED;
               event_code = EV_DISARMED;
            end else begin
               enable_in  = 1'b0;
               state_in   = ST_KILLED;
               event_code = EV_KILLED;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_DISARMED;
         enable_ff   <= 1'b1;
         throttle_ff <= MIN_PULSE_RST;
         silence_ff  <= '0;
         report_ff   <= '0;
      end else if (step_en) begin
         state_ff    <= state_in;
         enable_ff   <= enable_in;
         throttle_ff <= throttle_in;
         silence_ff  <= silence_in;
         report_ff   <= report_in;
      end
   end

   assign result.pulse_width  = throttle_in;
   assign result.drive_enable = enable_in;
   assign result.arm_state    = state_in;
   assign result.event_res    = event_code;
   assign result.report_due   = due;

endmodule

FILE: rtl/motor_arming_failsafe_controller.sv
// Top level of the motor arming and failsafe controller.
// Depends on mafc_pkg, mafc_if, mafc_line and mafc_ctrl.
//
// Usage:
// The req channel carries one beat per event: a received command byte
// (mode 0), a millisecond tick (mode 1) or a kill-button press (mode 2).
// Any other mode is taken and answered with the current state and no event.
// Every req beat yields exactly one rsp beat, in order, carrying the throttle
// pulse width, the drive enable, the arming state, the event code and the
// report flag of that beat.
// A beat accepted at a clock edge is captured in the input register; it is
// worked out when it moves on to the result register, which drives rsp.valid.
// One beat a cycle is sustained while rsp.ready stays high: the single
// pass of command decode, throttle clamp and timer compare sits between the
// input register and the result register.
// When the receiver holds rsp.ready low, the result register holds its beat
// and the input register can still take one more beat; after that req.ready
// falls until the result is taken. No beat is lost or repeated.
// The csr port writes min_pulse, max_pulse, timeout_ticks and report_period
// at indexes 0 to 3; write only while no beat is in flight.
// A synchronous reset restores the register defaults (1000, 2000, 500, 100),
// disarms the controller, enables the drive, sets the throttle to 1000 and
// empties both pipeline registers.
module motor_arming_failsafe_controller (
   input  logic                             clock,
   input  logic                             reset,
   mafc_req_if.sink                         req,
   mafc_rsp_if.source                       rsp,
   input  logic                             csr_we,
   input  logic [mafc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mafc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mafc_pkg::*;

   // Input register stage.
   logic              in_valid_ff;
   logic [MODE_W-1:0] in_mode_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // Result register stage.
   logic       out_valid_ff;
   result_type out_ff;

   cfg_type       cfg_ff;
   line_info_type line_info;
   result_type    result;
   logic          step_en;
   logic          take_req;

   // The held beat moves on whenever the result register is empty or is
   // being emptied in this cycle.
   assign step_en   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || step_en;
   assign take_req  = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_mode_ff <= req.mode;
         in_byte_ff <= req.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_ff <= result;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse     <= MIN_PULSE_RST;
         cfg_ff.max_pulse     <= MAX_PULSE_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_RST;
         cfg_ff.report_period <= REPORT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_PULSE:     cfg_ff.min_pulse     <= csr_wdata[PULSE_W-1:0];
            CSR_MAX_PULSE:     cfg_ff.max_pulse     <= csr_wdata[PULSE_W-1:0];
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata[TICK_W-1:0];
            CSR_REPORT_PERIOD: cfg_ff.report_period <= csr_wdata[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mafc_line u_line (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .mode      (in_mode_ff),
      .rx_byte   (in_byte_ff),
      .line_info (line_info)
   );

   mafc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .mode      (in_mode_ff),
      .rx_byte   (in_byte_ff),
      .line_info (line_info),
      .cfg       (cfg_ff),
      .result    (result)
   );

   assign rsp.valid        = out_valid_ff;
   assign rsp.pulse_width  = out_ff.pulse_width;
   assign rsp.drive_enable = out_ff.drive_enable;
   assign rsp.arm_state    = out_ff.arm_state;
   assign rsp.event_res    = out_ff.event_res;
   assign rsp.report_due   = out_ff.report_due;

endmodule
